// File: hdl/dqms_pkg.sv
// ----------------------------------------------------------------------------
// dqms_pkg: shared types and constants for the searchable deque
// Opcodes, status codes, store depth and the packed command/result words.
// ----------------------------------------------------------------------------
`default_nettype none

package dqms_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] OP_PUSH_REAR  = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_POP_BACK   = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_SEARCH     = 3'd4;
    localparam logic [2:0] OP_RESIZE     = 3'd5;
    localparam logic [2:0] OP_CLEAR      = 3'd6;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic [4:0]         tgt_size;
    } t_in;

    typedef struct packed {
        logic       found;
        logic [4:0] count;
        logic [1:0] status;
    } t_out;

endpackage

`default_nettype wire

// File: hdl/dqms_store.sv
// ----------------------------------------------------------------------------
// dqms_store: entry registers, occupancy count and command execution
// Applies one command per enabled cycle; result is combinational from state and the command.
// ----------------------------------------------------------------------------
`default_nettype none

module dqms_store (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire dqms_pkg::t_in i_cmd,
    output dqms_pkg::t_out     o_res
);

    localparam int CW = dqms_pkg::CNT_W;
    localparam int TW = (CW > 5) ? CW : 5;

    logic [31:0]           r_ent [dqms_pkg::DEPTH];
    logic [31:0]           n_ent [dqms_pkg::DEPTH];
    logic [CW-1:0]         r_cnt;
    logic [CW-1:0]         n_cnt;
    logic [CW-1:0]         tgt;
    logic [dqms_pkg::DEPTH-1:0] hit;
    logic                  full;
    logic                  empty;
    logic                  do_pushb;
    logic                  do_pushf;
    logic                  do_popf;
    logic                  do_resize;
    logic [1:0]            status;

    assign full  = (r_cnt == CW'(dqms_pkg::DEPTH));
    assign empty = (r_cnt == '0);

    // resize target saturates at capacity
    assign tgt = (TW'(i_cmd.tgt_size) > TW'(dqms_pkg::DEPTH))
               ? CW'(dqms_pkg::DEPTH) : CW'(i_cmd.tgt_size);

    assign do_pushb  = (i_cmd.op == dqms_pkg::OP_PUSH_REAR) && !full;
    assign do_pushf  = (i_cmd.op == dqms_pkg::OP_PUSH_FRONT) && !full;
    assign do_popf   = (i_cmd.op == dqms_pkg::OP_POP_FRONT) && !empty;
    assign do_resize = (i_cmd.op == dqms_pkg::OP_RESIZE);

    // per-slot next value: shift up, shift down, back write, zero fill
    for (genvar g = 0; g < dqms_pkg::DEPTH; g++) begin : g_slot
        logic [31:0] below;
        logic [31:0] above;

        if (g == 0) begin : g_first
            assign below = i_cmd.value;
        end else begin : g_rest
            assign below = r_ent[g-1];
        end

        if (g == dqms_pkg::DEPTH - 1) begin : g_last
            assign above = r_ent[g];
        end else begin : g_mid
            assign above = r_ent[g+1];
        end

        always_comb begin
            n_ent[g] = r_ent[g];
            if (do_pushf) begin
                n_ent[g] = below;
            end else if (do_popf) begin
                n_ent[g] = above;
            end else if (do_pushb && (CW'(g) == r_cnt)) begin
                n_ent[g] = i_cmd.value;
            end else if (do_resize && (CW'(g) >= r_cnt) && (CW'(g) < tgt)) begin
                n_ent[g] = '0;
            end
        end

        assign hit[g] = (CW'(g) < r_cnt) && (r_ent[g] == i_cmd.value);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ent[g] <= n_ent[g];
            end
        end
    end

    always_comb begin
        n_cnt  = r_cnt;
        status = dqms_pkg::ST_DONE;
        case (i_cmd.op)
            dqms_pkg::OP_PUSH_REAR, dqms_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    status = dqms_pkg::ST_FULL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            dqms_pkg::OP_POP_BACK, dqms_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    status = dqms_pkg::ST_EMPTY;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            dqms_pkg::OP_RESIZE: begin
                n_cnt = tgt;
            end
            dqms_pkg::OP_CLEAR: begin
                n_cnt = '0;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_en) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_res.found  = (i_cmd.op == dqms_pkg::OP_SEARCH) && (|hit);
    assign o_res.count  = 5'(n_cnt);
    assign o_res.status = status;

    a_cnt_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(dqms_pkg::DEPTH))
        else $error("occupancy above capacity");

    a_full_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && full && (i_cmd.op == dqms_pkg::OP_PUSH_REAR
                       || i_cmd.op == dqms_pkg::OP_PUSH_FRONT))
        |=> r_cnt == $past(r_cnt))
        else $error("push on full store changed occupancy");

    a_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_cmd.op == dqms_pkg::OP_CLEAR) |=> r_cnt == '0)
        else $error("clear left entries occupied");

    a_popf : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && do_popf) |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("pop front did not drop one word");

endmodule

`default_nettype wire

// File: hdl/deque_with_membership_search.sv
// A command word is loaded into the input register on acceptance; its result
// goes into the result register when it executes, once the result slot is free.
// Throughput: one command word per cycle while the output is not stalled; the
// entry shift registers and the 16-way parallel compare work combinationally.
// Reset clears the occupancy count and both stage valids; entry contents are
// not cleared and are only visible after a push or resize writes them.
// ----------------------------------------------------------------------------
// deque_with_membership_search: bounded deque with value search
// Valid/ready command channel in, one status word out per command.
// ----------------------------------------------------------------------------
`default_nettype none

module deque_with_membership_search (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire dqms_pkg::t_in  i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output dqms_pkg::t_out      o_out_data
);

    logic           r_in_vld;
    logic           n_in_vld;
    dqms_pkg::t_in  r_in;
    logic           r_out_vld;
    logic           n_out_vld;
    dqms_pkg::t_out r_out;
    dqms_pkg::t_out res;
    logic           adv;
    logic           take;

    // command in the input register executes when the result slot frees up
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;
    assign take       = i_in_valid && o_in_ready;

    dqms_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_cmd   (r_in),
        .o_res   (res)
    );

    always_comb begin
        n_in_vld = r_in_vld;
        if (take) begin
            n_in_vld = 1'b1;
        end else if (adv) begin
            n_in_vld = 1'b0;
        end

        n_out_vld = r_out_vld;
        if (adv) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// File: bench/deque_with_membership_search_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_membership_search_tb: self-checking bench for the searchable deque
// Drives command words with random gaps and output stalls, keeps its own copy
// of the deque and compares each result word against it in order.
// ----------------------------------------------------------------------------

module deque_with_membership_search_tb;

    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam int         N_RANDOM  = 930;

    // ------------------------------------------------------------------------
    // Deque predictor and result scoreboard
    // ------------------------------------------------------------------------
    class deque_scoreboard;
        logic signed [31:0] slots [dqms_pkg::DEPTH];
        int                 fill;
        dqms_pkg::t_out     pending_results [$];
        int                 mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function void apply_command(dqms_pkg::t_in c);
            dqms_pkg::t_out r;
            int             tgt;
            r.found  = 1'b0;
            r.status = dqms_pkg::ST_DONE;
            case (c.op)
                dqms_pkg::OP_PUSH_REAR: begin
                    if (fill >= dqms_pkg::DEPTH) begin
                        r.status = dqms_pkg::ST_FULL;
                    end else begin
                        slots[fill] = c.value;
                        fill++;
                    end
                end
                dqms_pkg::OP_PUSH_FRONT: begin
                    if (fill >= dqms_pkg::DEPTH) begin
                        r.status = dqms_pkg::ST_FULL;
                    end else begin
                        for (int i = fill; i > 0; i--) slots[i] = slots[i-1];
                        slots[0] = c.value;
                        fill++;
                    end
                end
                dqms_pkg::OP_POP_BACK: begin
                    if (fill == 0) r.status = dqms_pkg::ST_EMPTY;
                    else fill--;
                end
                dqms_pkg::OP_POP_FRONT: begin
                    if (fill == 0) begin
                        r.status = dqms_pkg::ST_EMPTY;
                    end else begin
                        for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
                        fill--;
                    end
                end
                dqms_pkg::OP_SEARCH: begin
                    for (int i = 0; i < fill; i++)
                        if (slots[i] == c.value) r.found = 1'b1;
                end
                dqms_pkg::OP_RESIZE: begin
                    tgt = (c.tgt_size > dqms_pkg::DEPTH) ? dqms_pkg::DEPTH
                                                         : int'(c.tgt_size);
                    // growing appends zero words at the back
                    for (int i = fill; i < tgt; i++) slots[i] = '0;
                    fill = tgt;
                end
                dqms_pkg::OP_CLEAR: fill = 0;
                default: ;
            endcase
            r.count = fill[4:0];
            pending_results = {pending_results, r};
        endfunction

        function void compare_result(dqms_pkg::t_out got);
            dqms_pkg::t_out want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: found=%0d count=%0d status=%0d",
                             got.found, got.count, got.status);
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found || got.count !== want.count
                    || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want %0d/%0d/%0d got %0d/%0d/%0d",
                             want.found, want.count, want.status,
                             got.found, got.count, got.status);
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function logic signed [31:0] stored_value();
            return slots[$urandom_range(fill - 1)];
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------------
    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    dqms_pkg::t_in  i_in_data   = '0;
    logic           i_out_ready = 1'b0;
    logic           o_in_ready;
    logic           o_out_valid;
    dqms_pkg::t_out o_out_data;

    logic steady = 1'b0;   // no stalls on either side while set

    deque_scoreboard sb;
    dqms_pkg::t_in   directed [$];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    deque_with_membership_search u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 27);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.compare_result(o_out_data);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic dqms_pkg::t_in cmd(logic [2:0] op, logic signed [31:0] value,
                                          logic [4:0] size);
        dqms_pkg::t_in c;
        c.op       = op;
        c.value    = value;
        c.tgt_size = size;
        return c;
    endfunction

    function automatic void add_directed(logic [2:0] op, logic signed [31:0] value,
                                         logic [4:0] size);
        directed = {directed, cmd(op, value, size)};
    endfunction

    // one command word: optional idle cycles, then hold valid until accepted
    task automatic run_command(input dqms_pkg::t_in c, input bit calm);
        while (!calm && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.apply_command(c);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    function automatic dqms_pkg::t_in random_command(bit grow);
        dqms_pkg::t_in c;
        int            r;
        int            push_w;
        int            pop_w;
        r      = $urandom_range(99);
        push_w = grow ? 56 : 24;
        pop_w  = grow ? 16 : 40;
        if (r < push_w)
            c.op = r[0] ? dqms_pkg::OP_PUSH_FRONT : dqms_pkg::OP_PUSH_REAR;
        else if (r < push_w + pop_w)
            c.op = r[0] ? dqms_pkg::OP_POP_FRONT : dqms_pkg::OP_POP_BACK;
        else if (r < 90)
            c.op = dqms_pkg::OP_SEARCH;
        else if (r < 95)
            c.op = dqms_pkg::OP_RESIZE;
        else if (r < 97)
            c.op = dqms_pkg::OP_CLEAR;
        else
            c.op = OP_UNUSED;

        c.value = $urandom;
        case ($urandom_range(7))
            0: c.value = 32'sh7fffffff;
            1: c.value = 32'sh80000000;
            2: c.value = '0;
            3: c.value = -32'sd1;
            default: ;
        endcase
        // searches hit a stored word about half the time
        if (c.op == dqms_pkg::OP_SEARCH && sb.fill > 0 && $urandom_range(1) == 1)
            c.value = sb.stored_value();

        c.tgt_size = ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                              : 5'($urandom_range(dqms_pkg::DEPTH));
        return c;
    endfunction

    initial begin
        bit calm;
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty-store pops, extremes, full-store pushes, resize saturation
        add_directed(dqms_pkg::OP_POP_BACK,   32'sd0,        5'd0);
        add_directed(dqms_pkg::OP_POP_FRONT,  -32'sd1,       5'd31);
        add_directed(dqms_pkg::OP_SEARCH,     32'sd0,        5'd0);
        add_directed(dqms_pkg::OP_PUSH_REAR,  32'sh7fffffff, 5'd0);
        add_directed(dqms_pkg::OP_PUSH_FRONT, 32'sh80000000, 5'd0);
        add_directed(dqms_pkg::OP_PUSH_REAR,  -32'sd1,       5'd0);
        add_directed(dqms_pkg::OP_SEARCH,     32'sh80000000, 5'd0);
        add_directed(dqms_pkg::OP_SEARCH,     32'sd12345,    5'd0);
        add_directed(dqms_pkg::OP_POP_FRONT,  32'sd0,        5'd0);
        add_directed(dqms_pkg::OP_SEARCH,     32'sh80000000, 5'd0);
        add_directed(dqms_pkg::OP_POP_BACK,   32'sd0,        5'd0);
        add_directed(dqms_pkg::OP_RESIZE,     32'sd0,        5'd16);
        add_directed(dqms_pkg::OP_PUSH_REAR,  32'sd5,        5'd0);
        add_directed(dqms_pkg::OP_PUSH_FRONT, 32'sd6,        5'd0);
        add_directed(dqms_pkg::OP_SEARCH,     32'sd0,        5'd0);
        add_directed(dqms_pkg::OP_SEARCH,     32'sh7fffffff, 5'd0);
        add_directed(dqms_pkg::OP_RESIZE,     32'sd0,        5'd31);
        add_directed(dqms_pkg::OP_RESIZE,     32'sd0,        5'd0);
        add_directed(OP_UNUSED,               32'sh5a5a5a5a, 5'd17);
        add_directed(dqms_pkg::OP_RESIZE,     -32'sd1,       5'd5);
        add_directed(dqms_pkg::OP_SEARCH,     32'sd0,        5'd0);
        add_directed(dqms_pkg::OP_CLEAR,      32'sd0,        5'd0);
        add_directed(dqms_pkg::OP_SEARCH,     32'sd0,        5'd0);
        add_directed(dqms_pkg::OP_RESIZE,     32'sd0,        5'd17);
        foreach (directed[i]) run_command(directed[i], 1'b0);
        drain();

        for (int k = 0; k < N_RANDOM; k++) begin
            calm = (k >= 300 && k < 450);
            steady <= calm;
            run_command(random_command((k / 64) % 2 == 0), calm);
            // hold off the sender until every result is back
            if (k == 600) drain();
        end

        drain();
        repeat (6) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
